/* src/evhv_pkg.sv */
// Shared types, constants and the FNV-1a round for the event packet hash validator.
package evhv_pkg;

  localparam int unsigned PAYLOAD_MAX = 256;
  localparam int unsigned SIZE_W      = $clog2(PAYLOAD_MAX + 2);
  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);
  localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);
  localparam int unsigned NUM_TIMING  = 5;
  localparam int unsigned NUM_STRINGS = 5;
  localparam int unsigned CNT_W       = 3;
  localparam int unsigned ADDR_W      = 5;

  localparam logic [31:0] FNV_BASIS = 32'd2166136261;
  localparam logic [31:0] FNV_PRIME = 32'd16777619;

  localparam logic [SIZE_W-1:0] SIZE_SAT = SIZE_W'(PAYLOAD_MAX + 1);

  localparam logic [7:0]  KIND_MIN_RST  = 8'd0;
  localparam logic [7:0]  KIND_MAX_RST  = 8'd15;
  localparam logic [7:0]  OBSERVE_RST   = 8'd15;
  localparam logic [31:0] T_MASTER_RST  = 32'd5040;
  localparam logic [31:0] T_PUBLIC_RST  = 32'd240;
  localparam logic [31:0] T_PRIVATE_RST = 32'd60;
  localparam logic [31:0] T_KERNEL_RST  = 32'd8;
  localparam logic [31:0] T_FANO_RST    = 32'd7;

  typedef enum logic [2:0] {
    REG_KIND_MIN  = 3'd0,
    REG_KIND_MAX  = 3'd1,
    REG_OBSERVE   = 3'd2,
    REG_T_MASTER  = 3'd3,
    REG_T_PUBLIC  = 3'd4,
    REG_T_PRIVATE = 3'd5,
    REG_T_KERNEL  = 3'd6,
    REG_T_FANO    = 3'd7
  } reg_e;

  typedef enum logic [2:0] {
    OP_KIND  = 3'd0,
    OP_STR   = 3'd1,
    OP_TIME  = 3'd2,
    OP_SIZE  = 3'd3,
    OP_PAY   = 3'd4,
    OP_CLAIM = 3'd5
  } op_e;

  typedef struct packed {
    logic [7:0]                       kind_min;
    logic [7:0]                       kind_max;
    logic [7:0]                       observe_kind;
    logic [NUM_TIMING-1:0][31:0]      timing;
  } cfg_t;

  typedef struct packed {
    op_e               op;
    logic [31:0]       data;
    logic              in_range;
    logic              is_observe;
    logic [SIZE_W-1:0] size;
  } entry_t;

  function automatic logic [31:0] fnv_fold(logic [31:0] h, logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * FNV_PRIME;
  endfunction

endpackage

/* src/event_packet_hash_validator.sv */
// Event packet FNV-1a hash validator: config registers, front end, queue and back end.
// A claim is written into the queue and its result is then registered in the back end's output register.
// Byte items go one per cycle unless a word is folding; words fold one hash round per cycle and block new requests.
// The queue holds four requests; input stalls only when it is full.
// Reset (async, active low) restores register defaults, empties the queue and clears packet state.
module event_packet_hash_validator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [evhv_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  in_kind_i,
  input  logic [31:0] in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_computed_hash_o,
  output logic        out_valid_res_o
);
  import evhv_pkg::*;

  cfg_t   cfg_q;
  reg_e   sel;
  logic   wr_en;
  logic   q_full, q_push, q_pop, q_valid;
  entry_t push_entry, head;

  assign pready = 1'b1;
  assign sel    = reg_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.kind_min     <= KIND_MIN_RST;
      cfg_q.kind_max     <= KIND_MAX_RST;
      cfg_q.observe_kind <= OBSERVE_RST;
      cfg_q.timing[0]    <= T_MASTER_RST;
      cfg_q.timing[1]    <= T_PUBLIC_RST;
      cfg_q.timing[2]    <= T_PRIVATE_RST;
      cfg_q.timing[3]    <= T_KERNEL_RST;
      cfg_q.timing[4]    <= T_FANO_RST;
    end else if (wr_en) begin
      case (sel)
        REG_KIND_MIN:  cfg_q.kind_min     <= pwdata[7:0];
        REG_KIND_MAX:  cfg_q.kind_max     <= pwdata[7:0];
        REG_OBSERVE:   cfg_q.observe_kind <= pwdata[7:0];
        REG_T_MASTER:  cfg_q.timing[0]    <= pwdata;
        REG_T_PUBLIC:  cfg_q.timing[1]    <= pwdata;
        REG_T_PRIVATE: cfg_q.timing[2]    <= pwdata;
        REG_T_KERNEL:  cfg_q.timing[3]    <= pwdata;
        REG_T_FANO:    cfg_q.timing[4]    <= pwdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_KIND_MIN:  prdata = {24'd0, cfg_q.kind_min};
      REG_KIND_MAX:  prdata = {24'd0, cfg_q.kind_max};
      REG_OBSERVE:   prdata = {24'd0, cfg_q.observe_kind};
      REG_T_MASTER:  prdata = cfg_q.timing[0];
      REG_T_PUBLIC:  prdata = cfg_q.timing[1];
      REG_T_PRIVATE: prdata = cfg_q.timing[2];
      REG_T_KERNEL:  prdata = cfg_q.timing[3];
      REG_T_FANO:    prdata = cfg_q.timing[4];
      default:       prdata = 32'd0;
    endcase
  end

  evhv_front u_front (
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_kind_i  (in_kind_i),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_entry_o  (push_entry)
  );

  evhv_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (q_push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .head_o       (head)
  );

  evhv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_entry_i   (head),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_hash_o  (out_computed_hash_o),
    .out_ok_o    (out_valid_res_o)
  );

endmodule

/* src/evhv_front.sv */
// Front end: accepts requests, drops unknown item kinds, decodes the item kind and precomputes kind and size checks.
module evhv_front (
  input  evhv_pkg::cfg_t   cfg_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       in_kind_i,
  input  logic [31:0]      in_data_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output evhv_pkg::entry_t q_entry_o
);
  import evhv_pkg::*;

  logic known;

  always_comb begin
    case (in_kind_i)
      OP_KIND, OP_STR, OP_TIME, OP_SIZE, OP_PAY, OP_CLAIM: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && known;

  always_comb begin
    q_entry_o.op         = op_e'(in_kind_i);
    q_entry_o.data       = in_data_i;
    q_entry_o.in_range   = (in_data_i >= {24'd0, cfg_i.kind_min}) &&
                           (in_data_i <= {24'd0, cfg_i.kind_max});
    q_entry_o.is_observe = in_data_i == {24'd0, cfg_i.observe_kind};
    q_entry_o.size       = (in_data_i > 32'(PAYLOAD_MAX)) ? SIZE_SAT : in_data_i[SIZE_W-1:0];
  end

endmodule

/* src/evhv_queue.sv */
// Short register queue between the front end and the back end.
module evhv_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  evhv_pkg::entry_t push_entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output evhv_pkg::entry_t head_o
);
  import evhv_pkg::*;

  entry_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;
  logic                do_pop;

  assign full_o  = cnt_q == QCNT_W'(QDEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + QCNT_W'(push_i) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_entry_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= QCNT_W'(QDEPTH))
    else $error("queue count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count missed a push");

endmodule

/* src/evhv_back.sv */
// Back end: folds bytes into the hash one round per cycle, tracks packet checks, emits results.
module evhv_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  evhv_pkg::cfg_t   cfg_i,
  input  logic             q_valid_i,
  input  evhv_pkg::entry_t q_entry_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [31:0]      out_hash_o,
  output logic             out_ok_o
);
  import evhv_pkg::*;

  logic [31:0]            hash_q, hash_d;
  logic [23:0]            word_q, word_d;
  logic [1:0]             rem_q, rem_d;
  logic [CNT_W-1:0]       str_cnt_q, str_cnt_d;
  logic                   at_start_q, at_start_d;
  logic [NUM_STRINGS-1:0] present_q, present_d;
  logic [CNT_W-1:0]       tim_cnt_q, tim_cnt_d;
  logic                   tim_ok_q, tim_ok_d;
  logic                   kin_q, kin_d;
  logic                   kobs_q, kobs_d;
  logic [SIZE_W-1:0]      dsize_q, dsize_d;
  logic [SIZE_W-1:0]      pcnt_q, pcnt_d;
  logic                   oval_q, oval_d;
  logic [31:0]            ohash_q, ohash_d;
  logic                   ook_q, ook_d;
  logic                   busy, out_free, pop, ok;
  logic [7:0]             b;

  assign busy     = rem_q != 2'd0;
  assign out_free = !oval_q || !out_stall_i;
  assign pop      = q_valid_i && !busy && ((q_entry_i.op != OP_CLAIM) || out_free);
  assign q_pop_o  = pop;
  assign b        = q_entry_i.data[7:0];

  assign ok = kin_q && tim_ok_q && (tim_cnt_q == CNT_W'(NUM_TIMING)) &&
              (str_cnt_q == CNT_W'(NUM_STRINGS)) && at_start_q &&
              (present_q[3:0] == 4'hf) && (kobs_q || present_q[4]) &&
              (dsize_q <= SIZE_W'(PAYLOAD_MAX)) && (pcnt_q == dsize_q) &&
              ((q_entry_i.data == 32'd0) || (q_entry_i.data == hash_q));

  always_comb begin
    hash_d     = hash_q;
    word_d     = word_q;
    rem_d      = rem_q;
    str_cnt_d  = str_cnt_q;
    at_start_d = at_start_q;
    present_d  = present_q;
    tim_cnt_d  = tim_cnt_q;
    tim_ok_d   = tim_ok_q;
    kin_d      = kin_q;
    kobs_d     = kobs_q;
    dsize_d    = dsize_q;
    pcnt_d     = pcnt_q;
    oval_d     = oval_q && out_stall_i;
    ohash_d    = ohash_q;
    ook_d      = ook_q;

    if (busy) begin
      hash_d = fnv_fold(hash_q, word_q[7:0]);
      word_d = {8'd0, word_q[23:8]};
      rem_d  = rem_q - 2'd1;
    end else if (pop) begin
      case (q_entry_i.op)
        OP_KIND: begin
          hash_d     = fnv_fold(FNV_BASIS, b);
          word_d     = q_entry_i.data[31:8];
          rem_d      = 2'd3;
          str_cnt_d  = '0;
          at_start_d = 1'b1;
          present_d  = '0;
          tim_cnt_d  = '0;
          tim_ok_d   = 1'b1;
          kin_d      = q_entry_i.in_range;
          kobs_d     = q_entry_i.is_observe;
          dsize_d    = '0;
          pcnt_d     = '0;
        end
        OP_STR: begin
          hash_d = fnv_fold(hash_q, b);
          if (b == 8'd0) begin
            at_start_d = 1'b1;
            if (str_cnt_q < CNT_W'(NUM_STRINGS + 1)) begin
              str_cnt_d = str_cnt_q + 1'b1;
            end
          end else begin
            at_start_d = 1'b0;
            if (str_cnt_q < CNT_W'(NUM_STRINGS)) begin
              present_d[str_cnt_q] = 1'b1;
            end
          end
        end
        OP_TIME: begin
          hash_d = fnv_fold(hash_q, b);
          word_d = q_entry_i.data[31:8];
          rem_d  = 2'd3;
          if (tim_cnt_q < CNT_W'(NUM_TIMING)) begin
            if (q_entry_i.data != cfg_i.timing[tim_cnt_q]) begin
              tim_ok_d = 1'b0;
            end
          end else begin
            tim_ok_d = 1'b0;
          end
          if (tim_cnt_q < CNT_W'(NUM_TIMING + 1)) begin
            tim_cnt_d = tim_cnt_q + 1'b1;
          end
        end
        OP_SIZE: begin
          hash_d  = fnv_fold(hash_q, b);
          word_d  = q_entry_i.data[31:8];
          rem_d   = 2'd3;
          dsize_d = q_entry_i.size;
        end
        OP_PAY: begin
          hash_d = fnv_fold(hash_q, b);
          if (pcnt_q < SIZE_SAT) begin
            pcnt_d = pcnt_q + 1'b1;
          end
        end
        OP_CLAIM: begin
          oval_d     = 1'b1;
          ohash_d    = hash_q;
          ook_d      = ok;
          hash_d     = FNV_BASIS;
          str_cnt_d  = '0;
          at_start_d = 1'b1;
          present_d  = '0;
          tim_cnt_d  = '0;
          tim_ok_d   = 1'b1;
          kin_d      = 1'b0;
          kobs_d     = 1'b0;
          dsize_d    = '0;
          pcnt_d     = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q     <= FNV_BASIS;
      rem_q      <= '0;
      str_cnt_q  <= '0;
      at_start_q <= 1'b1;
      present_q  <= '0;
      tim_cnt_q  <= '0;
      tim_ok_q   <= 1'b1;
      kin_q      <= 1'b0;
      kobs_q     <= 1'b0;
      dsize_q    <= '0;
      pcnt_q     <= '0;
      oval_q     <= 1'b0;
    end else begin
      hash_q     <= hash_d;
      rem_q      <= rem_d;
      str_cnt_q  <= str_cnt_d;
      at_start_q <= at_start_d;
      present_q  <= present_d;
      tim_cnt_q  <= tim_cnt_d;
      tim_ok_q   <= tim_ok_d;
      kin_q      <= kin_d;
      kobs_q     <= kobs_d;
      dsize_q    <= dsize_d;
      pcnt_q     <= pcnt_d;
      oval_q     <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q  <= word_d;
    ohash_q <= ohash_d;
    ook_q   <= ook_d;
  end

  assign out_valid_o = oval_q;
  assign out_hash_o  = ohash_q;
  assign out_ok_o    = ook_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |-> !q_pop_o)
    else $error("request taken while a word is still folding");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (q_entry_i.op == OP_TIME)) |=> rem_q == 2'd3)
    else $error("word request did not start a fold sequence");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (oval_q && out_stall_i) |-> !(q_pop_o && (q_entry_i.op == OP_CLAIM)))
    else $error("claim taken while result register is blocked");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (str_cnt_q <= CNT_W'(NUM_STRINGS + 1)) && (tim_cnt_q <= CNT_W'(NUM_TIMING + 1)) &&
    (pcnt_q <= SIZE_SAT))
    else $error("packet counter beyond saturation");

endmodule

/* sim/event_packet_hash_validator_test.sv */
// Self-checking testbench for the event packet FNV-1a hash validator.
`timescale 1ns / 1ps

module event_packet_hash_validator_test;
  import evhv_pkg::*;

  localparam logic [2:0] KIND_SPARE_A  = 3'd6;
  localparam logic [2:0] KIND_SPARE_B  = 3'd7;
  localparam int         RANDOM_ITEMS  = 1250;
  localparam int         HOLD_CYCLES   = 300;
  localparam int         SETTLE_CYCLES = 40;
  localparam int         STUCK_LIMIT   = 3000;

  typedef enum int {
    FLAW_NONE,
    FLAW_KIND_RANGE,
    FLAW_NO_KIND,
    FLAW_EMPTY_STR,
    FLAW_NO_TERM,
    FLAW_EXTRA_STR,
    FLAW_TIMING_VALUE,
    FLAW_TIMING_EXTRA,
    FLAW_TIMING_SHORT,
    FLAW_SIZE_OVER,
    FLAW_SIZE_REPEAT,
    FLAW_PAY_COUNT,
    FLAW_CLAIM,
    FLAW_SPARE_KIND,
    FLAW_ORDER
  } flaw_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] data;
  } request_t;

  typedef struct packed {
    logic [31:0] hash;
    logic        ok;
  } verdict_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [2:0]  in_kind_i;
  logic [31:0] in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [31:0] out_computed_hash_o;
  logic        out_valid_res_o;

  event_packet_hash_validator dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_kind_i           (in_kind_i),
    .in_data_i           (in_data_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_computed_hash_o (out_computed_hash_o),
    .out_valid_res_o     (out_valid_res_o)
  );

  logic [7:0]  cfg_kind_min;
  logic [7:0]  cfg_kind_max;
  logic [7:0]  cfg_observe;
  logic [31:0] cfg_timing [NUM_TIMING];

  logic [31:0]       run_hash;
  logic [CNT_W-1:0]  str_count;
  logic              str_boundary;
  logic [4:0]        str_seen;
  logic [CNT_W-1:0]  time_count;
  logic              time_ok;
  logic              pkt_in_range;
  logic              pkt_observe;
  logic [SIZE_W-1:0] size_decl;
  logic [SIZE_W-1:0] pay_count;

  verdict_t pending_verdicts [$];
  verdict_t head;
  int       mismatches   = 0;
  int       sent_items   = 0;
  int       stuck_cycles = 0;
  int       hold_left    = 0;
  int       stall_left   = 0;
  bit       steady       = 0;
  bit       hold_req     = 0;

  always #6 clk_i = ~clk_i;

  function automatic logic [31:0] fnv_byte(logic [31:0] h, logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'd0, b};
    return x * 32'd16777619;
  endfunction

  function automatic logic [31:0] fnv_word(logic [31:0] h, logic [31:0] w);
    logic [31:0] acc;
    acc = h;
    for (int i = 0; i < 4; i++) acc = fnv_byte(acc, w[8*i +: 8]);
    return acc;
  endfunction

  function automatic void clear_packet();
    run_hash     = FNV_BASIS;
    str_count    = '0;
    str_boundary = 1'b1;
    str_seen     = '0;
    time_count   = '0;
    time_ok      = 1'b1;
    pkt_in_range = 1'b0;
    pkt_observe  = 1'b0;
    size_decl    = '0;
    pay_count    = '0;
  endfunction

  function automatic void advance_packet(logic [2:0] kind, logic [31:0] data);
    verdict_t v;
    logic [7:0] b;
    b = data[7:0];
    case (kind)
      OP_KIND: begin
        clear_packet();
        run_hash     = fnv_word(run_hash, data);
        pkt_in_range = data >= {24'd0, cfg_kind_min} && data <= {24'd0, cfg_kind_max};
        pkt_observe  = data == {24'd0, cfg_observe};
      end
      OP_STR: begin
        run_hash = fnv_byte(run_hash, b);
        if (b == 8'd0) begin
          str_boundary = 1'b1;
          if (str_count < 3'd6) str_count++;
        end else begin
          str_boundary = 1'b0;
          if (str_count < 3'd5) str_seen[str_count] = 1'b1;
        end
      end
      OP_TIME: begin
        run_hash = fnv_word(run_hash, data);
        if (time_count < 3'd5) begin
          if (data != cfg_timing[time_count]) time_ok = 1'b0;
        end else begin
          time_ok = 1'b0;
        end
        if (time_count < 3'd6) time_count++;
      end
      OP_SIZE: begin
        run_hash  = fnv_word(run_hash, data);
        size_decl = (data > PAYLOAD_MAX) ? SIZE_SAT : data[SIZE_W-1:0];
      end
      OP_PAY: begin
        run_hash = fnv_byte(run_hash, b);
        if (pay_count < SIZE_SAT) pay_count++;
      end
      OP_CLAIM: begin
        v.hash = run_hash;
        v.ok   = pkt_in_range && time_ok && time_count == 3'd5 && str_count == 3'd5 &&
                 str_boundary && str_seen[3:0] == 4'hf && (pkt_observe || str_seen[4]) &&
                 size_decl <= PAYLOAD_MAX && pay_count == size_decl &&
                 (data == 32'd0 || data == run_hash);
        pending_verdicts.push_back(v);
        clear_packet();
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99, 0);
    if (steady || r < 70) return 0;
    if (r < 96) return $urandom_range(3, 1);
    return $urandom_range(30, 8);
  endfunction

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        report("result with none pending", out_computed_hash_o, 32'd0);
      end else begin
        head = pending_verdicts.pop_front();
        if (out_computed_hash_o !== head.hash) report("computed_hash", out_computed_hash_o, head.hash);
        if (out_valid_res_o !== head.ok) report("valid_res", 32'(out_valid_res_o), 32'(head.ok));
      end
    end
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req <= 1'b0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      stall_left = pick_gap();
      out_stall_i <= stall_left > 0;
      if (stall_left > 0) stall_left--;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || (psel && penable))
        stuck_cycles = 0;
      else
        stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [2:0] kind, input logic [31:0] data);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_kind_i  <= kind;
    in_data_i  <= data;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    advance_packet(kind, data);
    if (kind <= OP_CLAIM) sent_items++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_KIND_MIN: cfg_kind_min = value[7:0];
      REG_KIND_MAX: cfg_kind_max = value[7:0];
      REG_OBSERVE:  cfg_observe  = value[7:0];
      default:      cfg_timing[idx - REG_T_MASTER] = value;
    endcase
  endtask

  task automatic configure(input logic [7:0] kmin, input logic [7:0] kmax, input logic [7:0] obs,
                           input logic [31:0] t0, input logic [31:0] t1, input logic [31:0] t2,
                           input logic [31:0] t3, input logic [31:0] t4);
    wait_idle();
    write_reg(REG_KIND_MIN, {24'd0, kmin});
    write_reg(REG_KIND_MAX, {24'd0, kmax});
    write_reg(REG_OBSERVE, {24'd0, obs});
    write_reg(REG_T_MASTER, t0);
    write_reg(REG_T_PUBLIC, t1);
    write_reg(REG_T_PRIVATE, t2);
    write_reg(REG_T_KERNEL, t3);
    write_reg(REG_T_FANO, t4);
  endtask

  function automatic request_t byte_req(logic [2:0] kind, logic [7:0] b);
    request_t r;
    r.kind      = kind;
    r.data      = $urandom;
    r.data[7:0] = b;
    return r;
  endfunction

  task automatic send_packet(input flaw_e flaw, input bit fix_size, input logic [31:0] size_val,
                             input int pay_bytes);
    request_t    body [$];
    request_t    tmp;
    logic [31:0] kind_word;
    logic [31:0] size;
    logic [31:0] claim;
    int          len;
    int          nbytes;
    int          empty_idx;
    int          bad_idx;
    int          ntiming;
    int          a;
    int          c;
    if (cfg_kind_min <= cfg_kind_max)
      kind_word = $urandom_range(cfg_kind_max, cfg_kind_min);
    else
      kind_word = $urandom_range(255, 0);
    if ($urandom_range(3, 0) == 0) kind_word = {24'd0, cfg_observe};
    if (flaw == FLAW_KIND_RANGE) begin
      if (cfg_kind_min > 0 && $urandom_range(1, 0))
        kind_word = $urandom_range(cfg_kind_min - 1, 0);
      else
        kind_word = $urandom | 32'h0000_0100;
    end
    if (flaw != FLAW_NO_KIND) body.push_back('{OP_KIND, kind_word});

    empty_idx = $urandom_range(4, 0);
    for (int i = 0; i < NUM_STRINGS; i++) begin
      len = $urandom_range(3, 1);
      if (i == 4 && kind_word == {24'd0, cfg_observe} && $urandom_range(1, 0)) len = 0;
      if (flaw == FLAW_EMPTY_STR && i == empty_idx) len = 0;
      repeat (len) body.push_back(byte_req(OP_STR, 8'($urandom_range(255, 1))));
      if (!(flaw == FLAW_NO_TERM && i == 4)) body.push_back(byte_req(OP_STR, 8'd0));
    end
    if (flaw == FLAW_EXTRA_STR) begin
      if ($urandom_range(1, 0)) body.push_back(byte_req(OP_STR, 8'($urandom_range(255, 1))));
      body.push_back(byte_req(OP_STR, 8'd0));
    end

    ntiming = (flaw == FLAW_TIMING_SHORT) ? $urandom_range(4, 0) : NUM_TIMING;
    bad_idx = $urandom_range(4, 0);
    for (int i = 0; i < ntiming; i++) begin
      if (flaw == FLAW_TIMING_VALUE && i == bad_idx)
        body.push_back('{OP_TIME, cfg_timing[i] ^ (32'd1 << $urandom_range(31, 0))});
      else
        body.push_back('{OP_TIME, cfg_timing[i]});
    end
    if (flaw == FLAW_TIMING_EXTRA) begin
      repeat ($urandom_range(2, 1)) body.push_back('{OP_TIME, cfg_timing[$urandom_range(4, 0)]});
    end

    size = fix_size ? size_val : 32'($urandom_range(6, 0));
    if (flaw == FLAW_SIZE_OVER) size = $urandom_range(1, 0) ? 32'd257 : ($urandom | 32'h200);
    if (flaw == FLAW_SIZE_REPEAT) body.push_back('{OP_SIZE, $urandom});
    body.push_back('{OP_SIZE, size});
    if (pay_bytes >= 0) nbytes = pay_bytes;
    else if (size > PAYLOAD_MAX) nbytes = $urandom_range(4, 0);
    else nbytes = size;
    if (flaw == FLAW_PAY_COUNT) nbytes = (nbytes > 0 && $urandom_range(1, 0)) ? nbytes - 1 : nbytes + 1;
    repeat (nbytes) body.push_back('{OP_PAY, $urandom});

    if (flaw == FLAW_SPARE_KIND) begin
      repeat ($urandom_range(3, 1))
        body.insert($urandom_range(body.size(), 0),
                    '{$urandom_range(1, 0) ? KIND_SPARE_A : KIND_SPARE_B, $urandom});
    end
    if (flaw == FLAW_ORDER) begin
      a = $urandom_range(body.size() - 1, 1);
      c = $urandom_range(body.size() - 1, 1);
      tmp     = body[a];
      body[a] = body[c];
      body[c] = tmp;
    end

    foreach (body[i]) send_item(body[i].kind, body[i].data);
    claim = $urandom_range(1, 0) ? 32'd0 : run_hash;
    if (flaw == FLAW_CLAIM) claim = run_hash ^ (32'd1 << $urandom_range(31, 0));
    send_item(OP_CLAIM, claim);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(12, 1)) send_item(3'($urandom_range(7, 0)), $urandom);
    if ($urandom_range(1, 0)) send_item(OP_CLAIM, $urandom_range(1, 0) ? 32'd0 : $urandom);
  endtask

  task automatic test_orphan_claim();
    send_item(OP_CLAIM, 32'd0);
    send_item(OP_CLAIM, FNV_BASIS);
    send_item(OP_CLAIM, 32'hffff_ffff);
  endtask

  task automatic test_reset_defaults();
    send_packet(FLAW_NONE, 1'b0, 32'd0, -1);
    send_item(KIND_SPARE_A, $urandom);
    send_item(KIND_SPARE_B, $urandom);
  endtask

  task automatic test_payload_limit();
    send_packet(FLAW_NONE, 1'b1, 32'd256, -1);
    send_packet(FLAW_NONE, 1'b1, 32'hffff_ffff, 260);
    wait_idle();
  endtask

  task automatic test_backpressure();
    steady = 1'b1;
    hold_req <= 1'b1;
    repeat (3) send_packet(FLAW_NONE, 1'b0, 32'd0, -1);
    repeat (8) send_item(OP_CLAIM, $urandom);
    steady = 1'b0;
    wait_idle();
  endtask

  task automatic random_phase(input int count);
    int start;
    int r;
    start = sent_items;
    while (sent_items - start < count) begin
      steady = $urandom_range(7, 0) == 0;
      r = $urandom_range(99, 0);
      if (r < 8)
        send_noise();
      else if (r < 55)
        send_packet(FLAW_NONE, 1'b0, 32'd0, -1);
      else
        send_packet(flaw_e'($urandom_range(FLAW_ORDER, FLAW_KIND_RANGE)), 1'b0, 32'd0, -1);
    end
    steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    logic [7:0] lo;
    int         share;
    lo = $urandom_range(200, 0);
    share = (RANDOM_ITEMS - sent_items) / 4;
    if (share < 50) share = 50;
    configure(lo, 8'($urandom_range(255, lo)), 8'($urandom_range(255, lo)),
              $urandom, $urandom, $urandom, $urandom, $urandom);
    random_phase(share);
    configure(8'd0, 8'd255, 8'd255, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
              32'hffff_ffff, 32'hffff_ffff);
    random_phase(share);
    configure(8'd255, 8'd255, 8'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
    random_phase(share);
    configure(8'($urandom_range(255, 129)), 8'($urandom_range(128, 0)), 8'($urandom),
              $urandom, $urandom, $urandom, $urandom, $urandom);
    random_phase(share);
  endtask

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid_i  = 1'b0;
    in_kind_i   = OP_KIND;
    in_data_i   = '0;
    out_stall_i = 1'b0;
    cfg_kind_min  = KIND_MIN_RST;
    cfg_kind_max  = KIND_MAX_RST;
    cfg_observe   = OBSERVE_RST;
    cfg_timing[0] = T_MASTER_RST;
    cfg_timing[1] = T_PUBLIC_RST;
    cfg_timing[2] = T_PRIVATE_RST;
    cfg_timing[3] = T_KERNEL_RST;
    cfg_timing[4] = T_FANO_RST;
    clear_packet();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_orphan_claim();
    test_reset_defaults();
    test_payload_limit();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    if (mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

/* files.f */
src/evhv_pkg.sv
src/evhv_front.sv
src/evhv_queue.sv
src/evhv_back.sv
src/event_packet_hash_validator.sv
sim/event_packet_hash_validator_test.sv
